[rtl/psg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package psg_pkg;

  // Window length is a power of two, given by its log.
  localparam int AVG_LOG2 = 4;
  localparam int AVG_LEN  = 1 << AVG_LOG2;
  localparam int PWR_W    = 32;
  localparam int SUM_W    = PWR_W + AVG_LOG2;
  localparam int GATE_W   = 16;
  localparam int CNT_W    = GATE_W + 1;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SQUELCH_LEVEL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GATE_SAMPLES  = CFG_IDX_W'(1);

  typedef struct packed {
    logic [PWR_W-1:0] power;
    logic [PWR_W-1:0] avg_power;
    logic             squelch_open;
    logic [CNT_W-1:0] gate_count;
  } psg_result_t;

  typedef struct packed {
    logic [PWR_W-1:0]  squelch_level;
    logic [GATE_W-1:0] gate_samples;
  } psg_cfg_t;

endpackage

`default_nettype wire

[rtl/psg_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module psg_cell (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     shift,
  input  wire logic [psg_pkg::PWR_W-1:0] d_in,
  output logic      [psg_pkg::PWR_W-1:0] q_out
);

  logic [psg_pkg::PWR_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift) begin
      q_r <= d_in;
    end
  end

  assign q_out = q_r;

endmodule

`default_nettype wire

[rtl/psg_window.sv]
`timescale 1ns / 1ps
`default_nettype none

module psg_window (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      shift,
  input  wire logic [psg_pkg::PWR_W-1:0] p_in,
  output logic      [psg_pkg::PWR_W-1:0] avg_nxt
);

  logic [psg_pkg::PWR_W-1:0] taps [psg_pkg::AVG_LEN];
  logic [psg_pkg::SUM_W-1:0] sum_r;
  logic [psg_pkg::SUM_W-1:0] sum_nxt;

  for (genvar k = 0; k < psg_pkg::AVG_LEN; k++) begin : g_cell
    if (k == 0) begin : g_head
      psg_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (shift),
        .d_in  (p_in),
        .q_out (taps[k])
      );
    end else begin : g_body
      psg_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (shift),
        .d_in  (taps[k-1]),
        .q_out (taps[k])
      );
    end
  end

  // Drop the oldest power, add the new one.
  assign sum_nxt = sum_r
                 - {{psg_pkg::AVG_LOG2{1'b0}}, taps[psg_pkg::AVG_LEN-1]}
                 + {{psg_pkg::AVG_LOG2{1'b0}}, p_in};

  assign avg_nxt = sum_nxt[psg_pkg::SUM_W-1:psg_pkg::AVG_LOG2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (shift) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/psg_gate.sv]
`timescale 1ns / 1ps
`default_nettype none

module psg_gate (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      load,
  input  wire logic                      valid_in,
  input  wire psg_pkg::psg_cfg_t         cfg,
  input  wire logic [psg_pkg::PWR_W-1:0] power_in,
  input  wire logic [psg_pkg::PWR_W-1:0] avg_in,
  output logic                           valid_out,
  output psg_pkg::psg_result_t           result
);

  logic [psg_pkg::CNT_W-1:0] cnt_r;
  logic [psg_pkg::CNT_W-1:0] cnt_nxt;
  logic [psg_pkg::CNT_W-1:0] cnt_lim;
  logic                      open_nxt;
  logic                      below;
  logic                      valid_r;
  psg_pkg::psg_result_t      result_r;

  assign below   = avg_in < cfg.squelch_level;
  assign cnt_lim = {cfg.gate_samples, 1'b0};

  always_comb begin
    cnt_nxt  = cnt_r;
    open_nxt = !below;
    if (cfg.gate_samples != '0) begin
      if (below) begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - psg_pkg::CNT_W'(1);
        end
      end else if (cnt_r < cnt_lim) begin
        cnt_nxt = cnt_r + psg_pkg::CNT_W'(1);
      end
      open_nxt = cnt_nxt >= {1'b0, cfg.gate_samples};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= valid_in;
      if (valid_in) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r.power        <= power_in;
      result_r.avg_power    <= avg_in;
      result_r.squelch_open <= open_nxt;
      result_r.gate_count   <= cnt_nxt;
    end
  end

  assign valid_out = valid_r;
  assign result    = result_r;

endmodule

`default_nettype wire

[rtl/power_squelch_gate_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Power squelch with hysteresis gate. One I/Q sample is taken per clock while
// in_stall is low, each giving one result; squaring, power sum, window update
// and gate decision are one stage each. The average is the sum over a row of
// window cells (16 by default, always a power of two) divided by the window
// length; the sustained rate of one sample per clock is set by the window sum,
// which updates once per cycle. Stages stall one by one from the output, so a
// held result does not stop the upstream stages filling. The user must write
// squelch_level and gate_samples via the cfg port while idle (not enforced).
module power_squelch_gate_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [15:0]            in_sample_i,
  input  wire logic signed [15:0]            in_sample_q,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [psg_pkg::PWR_W-1:0]          out_power,
  output logic [psg_pkg::PWR_W-1:0]          out_avg_power,
  output logic                               out_squelch_open,
  output logic [psg_pkg::CNT_W-1:0]          out_gate_count,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [psg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);

  psg_pkg::psg_cfg_t    cfg_r;
  psg_pkg::psg_result_t result;

  logic                      v1_r, v2_r, v3_r;
  logic                      e1, e2, e3, e4;
  logic [30:0]               sqi_r, sqq_r;
  logic signed [31:0]        prod_i, prod_q;
  logic [psg_pkg::PWR_W-1:0] p2_r, p3_r;
  logic [psg_pkg::PWR_W-1:0] p2_nxt;
  logic [psg_pkg::PWR_W-1:0] avg_nxt;
  logic [psg_pkg::PWR_W-1:0] avg3_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        psg_pkg::REG_SQUELCH_LEVEL: cfg_r.squelch_level <= cfg_data;
        psg_pkg::REG_GATE_SAMPLES:  cfg_r.gate_samples  <= cfg_data[psg_pkg::GATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Each stage advances when empty or when the next one advances.
  assign e4       = !out_valid || !out_stall;
  assign e3       = !v3_r || e4;
  assign e2       = !v2_r || e3;
  assign e1       = !v1_r || e2;
  assign in_stall = !e1;

  assign prod_i = in_sample_i * in_sample_i;
  assign prod_q = in_sample_q * in_sample_q;
  assign p2_nxt = {1'b0, sqi_r} + {1'b0, sqq_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (e1) v1_r <= in_valid;
      if (e2) v2_r <= v1_r;
      if (e3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (e1) begin
      sqi_r <= prod_i[30:0];
      sqq_r <= prod_q[30:0];
    end
    if (e2) begin
      p2_r <= p2_nxt;
    end
    if (e3) begin
      p3_r   <= p2_r;
      avg3_r <= avg_nxt;
    end
  end

  psg_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .shift   (e3 && v2_r),
    .p_in    (p2_r),
    .avg_nxt (avg_nxt)
  );

  psg_gate u_gate (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (e4),
    .valid_in  (v3_r),
    .cfg       (cfg_r),
    .power_in  (p3_r),
    .avg_in    (avg3_r),
    .valid_out (out_valid),
    .result    (result)
  );

  assign out_power        = result.power;
  assign out_avg_power    = result.avg_power;
  assign out_squelch_open = result.squelch_open;
  assign out_gate_count   = result.gate_count;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && v1_r && v2_r && v3_r))
    else $error("input stalled while a stage was free");

  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_power <= 32'h8000_0000))
    else $error("power out of range");

  a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_avg_power <= 32'h8000_0000))
    else $error("window average out of range");

endmodule

`default_nettype wire

[bench/tb_power_squelch_gate_top.sv]
`timescale 1ns / 1ps

module tb_power_squelch_gate_top;
  import psg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = CFG_IDX_W'(255);

  class squelch_scoreboard;
    psg_cfg_t                  cfg;
    logic [PWR_W-1:0]          window [AVG_LEN];
    logic [SUM_W-1:0]          acc_sum;
    logic [AVG_LOG2-1:0]       slot;
    logic [CNT_W-1:0]          counter;
    psg_result_t               pending [$];
    int                        errors;

    function new();
      cfg     = '0;
      acc_sum = '0;
      slot    = '0;
      counter = '0;
      errors  = 0;
      foreach (window[k]) window[k] = '0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_SQUELCH_LEVEL: cfg.squelch_level = data;
        REG_GATE_SAMPLES:  cfg.gate_samples  = data[GATE_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic signed [15:0] si, logic signed [15:0] sq);
      longint      ii;
      longint      qq;
      logic        below;
      psg_result_t r;
      ii = si;
      qq = sq;
      r.power = PWR_W'(ii * ii + qq * qq);
      acc_sum = acc_sum - SUM_W'(window[slot]) + SUM_W'(r.power);
      window[slot] = r.power;
      slot = slot + 1'b1;
      r.avg_power = PWR_W'(acc_sum >> AVG_LOG2);
      // strict compare: a level of zero is never undercut
      below = r.avg_power < cfg.squelch_level;
      if (cfg.gate_samples != 0) begin
        if (below) begin
          if (counter != 0) counter = counter - 1'b1;
        end else if (counter < {cfg.gate_samples, 1'b0}) begin
          counter = counter + 1'b1;
        end
        r.squelch_open = counter >= CNT_W'(cfg.gate_samples);
      end else begin
        r.squelch_open = !below;
      end
      r.gate_count = counter;
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(psg_result_t got);
      psg_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with no request waiting, power %0d", got.power));
        return;
      end
      want = pending.pop_front();
      if (got.power !== want.power)
        report($sformatf("power %0d, want %0d", got.power, want.power));
      if (got.avg_power !== want.avg_power)
        report($sformatf("avg_power %0d, want %0d", got.avg_power, want.avg_power));
      if (got.squelch_open !== want.squelch_open)
        report($sformatf("squelch_open %b, want %b", got.squelch_open, want.squelch_open));
      if (got.gate_count !== want.gate_count)
        report($sformatf("gate_count %0d, want %0d", got.gate_count, want.gate_count));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [15:0]   in_sample_i;
  logic signed [15:0]   in_sample_q;
  logic                 out_valid;
  logic                 out_stall;
  logic [PWR_W-1:0]     out_power;
  logic [PWR_W-1:0]     out_avg_power;
  logic                 out_squelch_open;
  logic [CNT_W-1:0]     out_gate_count;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  squelch_scoreboard sb = new();
  psg_result_t       seen;
  int                send_idle_pct;
  int                stall_pct;
  int                hold_left;

  power_squelch_gate_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_i      (in_sample_i),
    .in_sample_q      (in_sample_q),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_power        (out_power),
    .out_avg_power    (out_avg_power),
    .out_squelch_open (out_squelch_open),
    .out_gate_count   (out_gate_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random stalls, or a long hold when one is requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      seen.power        = out_power;
      seen.avg_power    = out_avg_power;
      seen.squelch_open = out_squelch_open;
      seen.gate_count   = out_gate_count;
      sb.check_result(seen);
    end
  end

  // called and returns at a falling edge; valid stays high for the next request
  task automatic send_sample(input logic signed [15:0] si, input logic signed [15:0] sq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_sample_i <= si;
    in_sample_q <= sq;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(si, sq);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    int spins = 0;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0 && spins < 5000) begin
      @(negedge clk);
      spins++;
    end
    repeat (8) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_component(int unsigned mag_log);
    logic signed [15:0] r;
    r = 16'($urandom);
    if ($urandom_range(15) == 0) return $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
    return r >>> (15 - mag_log);
  endfunction

  // bursts of one magnitude, so the average swings across the level
  task automatic send_bursts(input int count);
    int          sent = 0;
    int unsigned mag;
    int          run;
    while (sent < count) begin
      mag = $urandom_range(15);
      run = $urandom_range(8, 40);
      repeat (run) begin
        send_sample(rand_component(mag), rand_component(mag));
        sent++;
      end
    end
  endtask

  task automatic random_setting(input bit widest_gate);
    logic [31:0] lvl;
    logic [15:0] gl;
    case ($urandom_range(5))
      0:       lvl = '0;
      1:       lvl = '1;
      default: lvl = $urandom >> $urandom_range(31);
    endcase
    case ($urandom_range(3))
      0:       gl = '0;
      1:       gl = 16'hffff;
      default: gl = 16'($urandom_range(1, 24));
    endcase
    if (widest_gate) gl = 16'hffff;
    write_reg(REG_SQUELCH_LEVEL, lvl);
    write_reg(REG_GATE_SAMPLES, {16'h0, gl});
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'(REG_FIRST_UNUSED + $urandom_range(200)), $urandom);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_sample_i   = '0;
    in_sample_q   = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // full-scale sample into an empty window lands exactly on the level: stays open
    write_reg(REG_SQUELCH_LEVEL, 32'h0800_0000);
    write_reg(REG_LAST_UNUSED, 32'hffff_ffff);
    send_sample(-16'sd32768, -16'sd32768);
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(16'sd1, -16'sd1);
    send_sample(-16'sd1, 16'sd0);
    wait_idle();
    // top level with no gate: always below
    write_reg(REG_SQUELCH_LEVEL, 32'hffff_ffff);
    send_sample(16'sd100, 16'sd100);
    send_sample(-16'sd32768, 16'sd0);
    wait_idle();
    // zero level never undercut: counter climbs to twice the gate and holds
    write_reg(REG_SQUELCH_LEVEL, 32'h0);
    write_reg(REG_GATE_SAMPLES, 32'd3);
    repeat (8) send_sample(16'sd100, -16'sd100);
    wait_idle();
    // gate lowered under the count: steps down only
    write_reg(REG_GATE_SAMPLES, 32'd1);
    write_reg(REG_SQUELCH_LEVEL, 32'hffff_ffff);
    repeat (4) send_sample(16'sd5, 16'sd5);
    wait_idle();

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 56; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      for (int k = 0; k < 2; k++) begin
        random_setting(mode == 0 && k == 0);
        if (mode == 0 && k == 1) hold_left = 300;
        send_bursts(250);
        wait_idle();
      end
    end

    send_idle_pct = 0;
    stall_pct     = 0;
    wait_idle();
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
